@@ design/lrast_pkg.sv @@
// Shared types and constants for the line rasterizer.
// Holds the word formats, the walker state record and the octant table.
// No dependencies.
`default_nettype none

package lrast_pkg;

  // Coordinate width of every column and row field
  localparam int CoordBits = 10;
  // Error term width: signed, spans +/- twice the largest delta
  localparam int ErrBits   = CoordBits + 3;

  typedef logic [CoordBits-1:0]        coord_t;
  typedef logic [CoordBits:0]          twice_t;
  typedef logic signed [ErrBits-1:0]   err_t;
  typedef logic [3:0]                  oct_code_t;

  // Word kinds
  localparam logic KindStart   = 1'b0;
  localparam logic KindAdvance = 1'b1;

  // Octant codes; zero means no line
  localparam oct_code_t OctIdle = 4'd0;
  localparam oct_code_t Oct1    = 4'd1;
  localparam oct_code_t Oct2    = 4'd2;
  localparam oct_code_t Oct3    = 4'd3;
  localparam oct_code_t Oct4    = 4'd4;
  localparam oct_code_t Oct5    = 4'd5;
  localparam oct_code_t Oct6    = 4'd6;
  localparam oct_code_t Oct7    = 4'd7;
  localparam oct_code_t Oct8    = 4'd8;

  // Error update and tie rule of an octant
  typedef enum logic [1:0] {
    RuleSubLt = 2'd0,  // e -= m, minor step if e < 0
    RuleSubLe = 2'd1,  // e -= m, minor step if e <= 0
    RuleAddGe = 2'd2,  // e += m, minor step if e >= 0
    RuleAddGt = 2'd3   // e += m, minor step if e > 0
  } rule_e;

  typedef struct packed {
    logic  xmaj;
    logic  xneg;
    logic  yneg;
    rule_e rule;
  } oct_info_t;

  typedef struct packed {
    logic        kind;
    coord_t      x_start;
    coord_t      y_start;
    coord_t      x_end;
    coord_t      y_end;
    logic [15:0] pen_color;
    logic [3:0]  pen_size;
  } lrast_in_t;

  typedef struct packed {
    logic        valid_res;
    coord_t      pixel_x;
    coord_t      pixel_y;
    logic [15:0] pixel_color;
    logic [3:0]  pixel_size;
    logic        last;
  } lrast_out_t;

  typedef struct packed {
    coord_t      cur_x;
    coord_t      cur_y;
    coord_t      goal_x;
    coord_t      goal_y;
    err_t        err_term;
    twice_t      twice_major;
    twice_t      twice_minor;
    oct_code_t   octant_code;
    logic        line_active;
    logic [15:0] held_color;
    logic [3:0]  held_size;
  } lrast_state_t;

  localparam lrast_state_t StateReset = '{
    cur_x:       '0,
    cur_y:       '0,
    goal_x:      '0,
    goal_y:      '0,
    err_term:    '0,
    twice_major: '0,
    twice_minor: '0,
    octant_code: OctIdle,
    line_active: 1'b0,
    held_color:  '0,
    held_size:   4'd1
  };

  // Axis roles and tie rule per octant code; unused codes walk as octant 1
  function automatic oct_info_t oct_info(input oct_code_t code);
    oct_info_t info;
    unique case (code)
      Oct2:    info = '{xmaj: 1'b0, xneg: 1'b0, yneg: 1'b0, rule: RuleSubLt};
      Oct3:    info = '{xmaj: 1'b0, xneg: 1'b1, yneg: 1'b0, rule: RuleSubLe};
      Oct4:    info = '{xmaj: 1'b1, xneg: 1'b1, yneg: 1'b0, rule: RuleAddGe};
      Oct5:    info = '{xmaj: 1'b1, xneg: 1'b1, yneg: 1'b1, rule: RuleAddGe};
      Oct6:    info = '{xmaj: 1'b0, xneg: 1'b1, yneg: 1'b1, rule: RuleAddGe};
      Oct7:    info = '{xmaj: 1'b0, xneg: 1'b0, yneg: 1'b1, rule: RuleAddGt};
      Oct8:    info = '{xmaj: 1'b1, xneg: 1'b0, yneg: 1'b1, rule: RuleSubLt};
      default: info = '{xmaj: 1'b1, xneg: 1'b0, yneg: 1'b0, rule: RuleSubLt};
    endcase
    return info;
  endfunction

endpackage

`default_nettype wire

@@ design/lrast_step.sv @@
// Combinational step of the line walker: line setup for a start word and
// one Bresenham step for an advance word. Uses lrast_pkg.
`default_nettype none

module lrast_step import lrast_pkg::*; (
  input  lrast_state_t state_i,
  input  lrast_in_t    word_i,
  output lrast_state_t state_o,
  output lrast_out_t   word_o
);

  // ---- line setup ----
  logic signed [CoordBits:0] dx, dy;
  coord_t    adx, ady, major, minor;
  logic      xmaj_s, xneg_s, yneg_s, point_s;
  oct_code_t oct_s;
  oct_info_t info_s;
  err_t      major_ext, err_init;

  assign dx = $signed({1'b0, word_i.x_end}) - $signed({1'b0, word_i.x_start});
  assign dy = $signed({1'b0, word_i.y_end}) - $signed({1'b0, word_i.y_start});
  assign xneg_s = dx[CoordBits];
  assign yneg_s = dy[CoordBits];
  assign adx = xneg_s ? coord_t'(-dx) : coord_t'(dx);
  assign ady = yneg_s ? coord_t'(-dy) : coord_t'(dy);
  assign xmaj_s  = (adx >= ady);
  assign point_s = (adx == '0) && (ady == '0);
  assign major = xmaj_s ? adx : ady;
  assign minor = xmaj_s ? ady : adx;

  // Pick the octant from the signs and the major axis
  always_comb begin
    unique case ({xmaj_s, xneg_s, yneg_s})
      3'b100:  oct_s = Oct1;
      3'b000:  oct_s = Oct2;
      3'b010:  oct_s = Oct3;
      3'b110:  oct_s = Oct4;
      3'b111:  oct_s = Oct5;
      3'b011:  oct_s = Oct6;
      3'b001:  oct_s = Oct7;
      default: oct_s = Oct8;
    endcase
  end

  assign info_s    = oct_info(oct_s);
  assign major_ext = signed'({{(ErrBits-CoordBits){1'b0}}, major});
  assign err_init  = (info_s.rule == RuleSubLt || info_s.rule == RuleSubLe) ?
                     major_ext : -major_ext;

  // ---- advance step ----
  oct_info_t info_a;
  coord_t    maj_cur, maj_nxt, maj_goal, min_cur, min_nxt;
  logic      maj_neg, min_neg, reached, sub_a, minor_step;
  err_t      m_ext, big_ext, err_1, err_2;

  assign info_a   = oct_info(state_i.octant_code);
  assign maj_cur  = info_a.xmaj ? state_i.cur_x  : state_i.cur_y;
  assign maj_goal = info_a.xmaj ? state_i.goal_x : state_i.goal_y;
  assign maj_neg  = info_a.xmaj ? info_a.xneg    : info_a.yneg;
  assign min_cur  = info_a.xmaj ? state_i.cur_y  : state_i.cur_x;
  assign min_neg  = info_a.xmaj ? info_a.yneg    : info_a.xneg;
  assign maj_nxt  = maj_neg ? maj_cur - coord_t'(1) : maj_cur + coord_t'(1);
  assign min_nxt  = min_neg ? min_cur - coord_t'(1) : min_cur + coord_t'(1);
  assign reached  = (maj_nxt == maj_goal);

  assign m_ext   = signed'({{(ErrBits-CoordBits-1){1'b0}}, state_i.twice_minor});
  assign big_ext = signed'({{(ErrBits-CoordBits-1){1'b0}}, state_i.twice_major});
  assign sub_a   = (info_a.rule == RuleSubLt) || (info_a.rule == RuleSubLe);
  assign err_1   = sub_a ? state_i.err_term - m_ext : state_i.err_term + m_ext;

  // Tie rule of the octant
  always_comb begin
    unique case (info_a.rule)
      RuleSubLt: minor_step = (err_1 <  0);
      RuleSubLe: minor_step = (err_1 <= 0);
      RuleAddGe: minor_step = (err_1 >= 0);
      default:   minor_step = (err_1 >  0);
    endcase
  end

  assign err_2 = !minor_step ? err_1 : (sub_a ? err_1 + big_ext : err_1 - big_ext);

  // ---- next state and result word ----
  always_comb begin
    state_o = state_i;
    word_o  = '0;
    if (word_i.kind == KindStart) begin
      state_o.held_color = word_i.pen_color;
      state_o.held_size  = word_i.pen_size;
      state_o.cur_x      = word_i.x_start;
      state_o.cur_y      = word_i.y_start;
      state_o.goal_x     = word_i.x_end;
      state_o.goal_y     = word_i.y_end;
      if (point_s) begin
        state_o.line_active = 1'b0;
        state_o.octant_code = OctIdle;
        state_o.err_term    = '0;
        state_o.twice_major = '0;
        state_o.twice_minor = '0;
      end else begin
        state_o.line_active = 1'b1;
        state_o.octant_code = oct_s;
        state_o.err_term    = err_init;
        state_o.twice_major = {major, 1'b0};
        state_o.twice_minor = {minor, 1'b0};
      end
      word_o.valid_res   = 1'b1;
      word_o.pixel_x     = word_i.x_start;
      word_o.pixel_y     = word_i.y_start;
      word_o.pixel_color = word_i.pen_color;
      word_o.pixel_size  = word_i.pen_size;
      word_o.last        = point_s;
    end else if (state_i.line_active) begin
      word_o.valid_res   = 1'b1;
      word_o.pixel_color = state_i.held_color;
      word_o.pixel_size  = state_i.held_size;
      if (reached) begin
        // Land exactly on the endpoint and drop the line
        state_o.cur_x       = state_i.goal_x;
        state_o.cur_y       = state_i.goal_y;
        state_o.line_active = 1'b0;
        word_o.pixel_x      = state_i.goal_x;
        word_o.pixel_y      = state_i.goal_y;
        word_o.last         = 1'b1;
      end else begin
        state_o.err_term = err_2;
        if (info_a.xmaj) begin
          state_o.cur_x = maj_nxt;
          state_o.cur_y = minor_step ? min_nxt : min_cur;
        end else begin
          state_o.cur_y = maj_nxt;
          state_o.cur_x = minor_step ? min_nxt : min_cur;
        end
        word_o.pixel_x = state_o.cur_x;
        word_o.pixel_y = state_o.cur_y;
      end
    end
  end

endmodule

`default_nettype wire

@@ design/line_rasterizer.sv @@
// Top level of the line rasterizer: input register, walker state, result
// register and handshakes. Uses lrast_pkg and lrast_step.
//
// Bresenham line walker over all eight octants. A start word loads both
// endpoints, color and dot size and returns the first pixel; each advance
// word returns the next pixel, the final one flagged last. An advance with
// no line active returns a word with valid_res clear and all fields zero.
// Every input word gives exactly one result word. Throughput is one word
// per clock while no stalled result holds the result register: the setup
// or step logic sits between the input register and the result register
// and updates the walker state in the same cycle. A taken word waits in
// the input register, and its result is then registered in the result
// register. The input stalls only while a stalled result word sits in the
// result register and the input register already holds the next word.
`default_nettype none

module line_rasterizer import lrast_pkg::*; (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        in_valid_i,
  output logic       in_stall_o,
  input  lrast_in_t  in_data_i,
  output logic       out_valid_o,
  input  wire        out_stall_i,
  output lrast_out_t out_data_o
);

  logic         in_valid_q;
  lrast_in_t    in_word_q;
  logic         out_valid_q;
  lrast_out_t   out_word_q;
  lrast_state_t state_q, state_d;
  lrast_out_t   res_d;
  logic         out_block, fire;

  // Result register full and not taken: hold the input word
  assign out_block  = out_valid_q && out_stall_i;
  assign fire       = in_valid_q && !out_block;
  assign in_stall_o = in_valid_q && out_block;

  lrast_step u_step (
    .state_i (state_q),
    .word_i  (in_word_q),
    .state_o (state_d),
    .word_o  (res_d)
  );

  // Control and walker state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= StateReset;
    end else begin
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (!out_block) begin
        out_valid_q <= fire;
      end
      if (fire) begin
        state_q <= state_d;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_word_q <= in_data_i;
    end
    if (fire) begin
      out_word_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_word_q;

endmodule

`default_nettype wire

@@ sim/tb_line_rasterizer.sv @@
// Testbench for line_rasterizer: drives start and advance words, walks each line in a
// local Bresenham model and compares every pixel word the block returns.
// Depends on lrast_pkg and line_rasterizer from the design folder.
`timescale 1ns / 1ps

module tb_line_rasterizer;
  import lrast_pkg::*;

  localparam int RandomWords = 1540;
  localparam int CycleLimit  = 200000;
  localparam int MaxReports  = 10;
  localparam int CoordMax    = (1 << CoordBits) - 1;

  // Receiver stall patterns
  typedef enum logic [1:0] {
    StallNone  = 2'd0,
    StallHeavy = 2'd1,
    StallLight = 2'd2,
    StallEvery = 2'd3
  } stall_mode_e;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  lrast_in_t  in_data_i;
  logic       out_valid_o;
  logic       out_stall_i;
  lrast_out_t out_data_o;

  line_rasterizer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Line walker model state
  coord_t      pos_x, pos_y, goal_x, goal_y;
  int          err_acc, dbl_major, dbl_minor;
  rule_e       walk_rule;
  logic        x_major, neg_x, neg_y, line_on;
  logic [15:0] pen_color_q;
  logic [3:0]  pen_size_q;

  lrast_out_t  expected_pixels[$];
  int          mismatches;
  int          words_sent;
  int          cycles;
  int          burst_left;
  bit          gaps_on;
  int          hold_len;
  int          hold_left;
  int          phase_left;
  stall_mode_e stall_mode;

  function automatic lrast_out_t pixel_word(input coord_t x, input coord_t y, input logic last);
    lrast_out_t p;
    p.valid_res   = 1'b1;
    p.pixel_x     = x;
    p.pixel_y     = y;
    p.pixel_color = pen_color_q;
    p.pixel_size  = pen_size_q;
    p.last        = last;
    return p;
  endfunction

  // Advance the model by one input word and return the pixel it produces
  function automatic lrast_out_t next_pixel(input lrast_in_t w);
    int   dx, dy, adx, ady, major, minor;
    logic reached, minor_step;
    if (w.kind == KindStart) begin
      dx = int'(w.x_end) - int'(w.x_start);
      dy = int'(w.y_end) - int'(w.y_start);
      adx = (dx < 0) ? -dx : dx;
      ady = (dy < 0) ? -dy : dy;
      pen_color_q = w.pen_color;
      pen_size_q  = w.pen_size;
      pos_x  = w.x_start;
      pos_y  = w.y_start;
      goal_x = w.x_end;
      goal_y = w.y_end;
      line_on = 1'b0;
      if (dx == 0 && dy == 0) return pixel_word(pos_x, pos_y, 1'b1);
      x_major = (adx >= ady);
      neg_x   = (dx < 0);
      neg_y   = (dy < 0);
      major   = x_major ? adx : ady;
      minor   = x_major ? ady : adx;
      dbl_major = 2 * major;
      dbl_minor = 2 * minor;
      // Pick the tie rule from the walk direction
      if (x_major) begin
        walk_rule = neg_x ? RuleAddGe : RuleSubLt;
      end else begin
        case ({neg_x, neg_y})
          2'b00:   walk_rule = RuleSubLt;
          2'b10:   walk_rule = RuleSubLe;
          2'b11:   walk_rule = RuleAddGe;
          default: walk_rule = RuleAddGt;
        endcase
      end
      err_acc = (walk_rule == RuleSubLt || walk_rule == RuleSubLe) ? major : -major;
      line_on = 1'b1;
      return pixel_word(pos_x, pos_y, 1'b0);
    end

    if (!line_on) return '0;

    // Step the major axis, finish at the endpoint
    if (x_major) begin
      pos_x   = neg_x ? pos_x - 1'b1 : pos_x + 1'b1;
      reached = (pos_x == goal_x);
    end else begin
      pos_y   = neg_y ? pos_y - 1'b1 : pos_y + 1'b1;
      reached = (pos_y == goal_y);
    end
    if (reached) begin
      pos_x   = goal_x;
      pos_y   = goal_y;
      line_on = 1'b0;
      return pixel_word(goal_x, goal_y, 1'b1);
    end

    // Update the error term and decide the minor step
    case (walk_rule)
      RuleSubLt: begin
        err_acc -= dbl_minor;
        minor_step = (err_acc < 0);
        if (minor_step) err_acc += dbl_major;
      end
      RuleSubLe: begin
        err_acc -= dbl_minor;
        minor_step = (err_acc <= 0);
        if (minor_step) err_acc += dbl_major;
      end
      RuleAddGe: begin
        err_acc += dbl_minor;
        minor_step = (err_acc >= 0);
        if (minor_step) err_acc -= dbl_major;
      end
      default: begin
        err_acc += dbl_minor;
        minor_step = (err_acc > 0);
        if (minor_step) err_acc -= dbl_major;
      end
    endcase
    if (minor_step) begin
      if (x_major) pos_y = neg_y ? pos_y - 1'b1 : pos_y + 1'b1;
      else         pos_x = neg_x ? pos_x - 1'b1 : pos_x + 1'b1;
    end
    return pixel_word(pos_x, pos_y, 1'b0);
  endfunction

  // Predict on every accepted input word
  always @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) expected_pixels.push_back(next_pixel(in_data_i));
  end

  task automatic check_pixel(input lrast_out_t want, input lrast_out_t got);
    string bad;
    bad = "";
    if (got.valid_res !== want.valid_res)     bad = {bad, " valid_res"};
    if (got.pixel_x !== want.pixel_x)         bad = {bad, " pixel_x"};
    if (got.pixel_y !== want.pixel_y)         bad = {bad, " pixel_y"};
    if (got.pixel_color !== want.pixel_color) bad = {bad, " pixel_color"};
    if (got.pixel_size !== want.pixel_size)   bad = {bad, " pixel_size"};
    if (got.last !== want.last)               bad = {bad, " last"};
    if (bad != "") begin
      mismatches++;
      if (mismatches <= MaxReports) begin
        $write("mismatch in%s: expected v=%0d x=%0d y=%0d c=%h s=%0d l=%0d,",
               bad, want.valid_res, want.pixel_x, want.pixel_y, want.pixel_color,
               want.pixel_size, want.last);
        $display(" got v=%0d x=%0d y=%0d c=%h s=%0d l=%0d",
                 got.valid_res, got.pixel_x, got.pixel_y,
                 got.pixel_color, got.pixel_size, got.last);
      end
    end
  endtask

  // Compare each returned word with the oldest prediction
  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) begin
      if (expected_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("unexpected word: x=%0d y=%0d last=%0d",
                   out_data_o.pixel_x, out_data_o.pixel_y, out_data_o.last);
      end else begin
        check_pixel(expected_pixels.pop_front(), out_data_o);
      end
    end
  end

  // Receiver: long hold-off on request, otherwise a random stall pattern per phase
  always @(posedge clk_i) begin
    if (hold_len != 0) begin
      hold_left = hold_len;
      hold_len  = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      if (phase_left == 0) begin
        stall_mode = stall_mode_e'($urandom_range(0, 3));
        phase_left = $urandom_range(16, 160);
      end
      phase_left--;
      case (stall_mode)
        StallNone:  out_stall_i <= 1'b0;
        StallHeavy: out_stall_i <= ($urandom_range(0, 1) == 0);
        StallLight: out_stall_i <= ($urandom_range(0, 9) == 0);
        default:    out_stall_i <= (phase_left % 3 == 0);
      endcase
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Offer one word and hold it until accepted; insert a gap between bursts
  task automatic send_word(input lrast_in_t w);
    int gap;
    if (gaps_on) begin
      if (burst_left == 0) begin
        gap = $urandom_range(1, 8);
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
        burst_left = $urandom_range(1, 40);
      end
      burst_left--;
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do @(posedge clk_i); while (in_stall_o);
    words_sent++;
  endtask

  // Drop valid and wait until every predicted word has come back
  task automatic wait_drain();
    in_valid_i <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (expected_pixels.size() != 0);
  endtask

  function automatic lrast_in_t noise_word(input logic kind);
    logic [63:0] r;
    lrast_in_t   w;
    r = {$urandom(), $urandom()};
    w = r[$bits(lrast_in_t)-1:0];
    w.kind = kind;
    return w;
  endfunction

  // Start a line, then advance n_adv times
  task automatic draw(input coord_t xs, input coord_t ys, input coord_t xe, input coord_t ye,
                      input logic [15:0] color, input logic [3:0] size, input int n_adv);
    lrast_in_t w;
    w = noise_word(KindStart);
    w.x_start   = xs;
    w.y_start   = ys;
    w.x_end     = xe;
    w.y_end     = ye;
    w.pen_color = color;
    w.pen_size  = size;
    send_word(w);
    repeat (n_adv) send_word(noise_word(KindAdvance));
  endtask

  function automatic int clamp_coord(input int v);
    return (v < 0) ? 0 : (v > CoordMax) ? CoordMax : v;
  endfunction

  function automatic int pick_coord();
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return CoordMax;
      default: return $urandom_range(0, CoordMax);
    endcase
  endfunction

  // Idle advances, a single point, one tie-step line per octant, axis lines at the edges
  task automatic test_directed();
    send_word(noise_word(KindAdvance));
    draw(1023, 0, 1023, 0, 16'hFFFF, 4'hF, 1);
    draw(512, 512, 516, 514, 16'h0000, 4'h0, 1);
    draw(512, 512, 514, 516, 16'hA5A5, 4'd1, 1);
    draw(512, 512, 510, 516, 16'h5A5A, 4'd2, 1);
    draw(512, 512, 508, 514, 16'h0F0F, 4'd3, 1);
    draw(512, 512, 508, 510, 16'hF0F0, 4'd4, 1);
    draw(512, 512, 510, 508, 16'h1234, 4'd5, 1);
    draw(512, 512, 514, 508, 16'h8001, 4'd6, 1);
    draw(512, 512, 516, 510, 16'h7FFE, 4'd8, 1);
    draw(1022, 1023, 1023, 1023, 16'hFFFF, 4'd7, 1);
    draw(1, 0, 0, 0, 16'h0000, 4'd8, 1);
    draw(0, 1022, 0, 1023, 16'hC3C3, 4'd1, 1);
    draw(1023, 1, 1023, 0, 16'h3C3C, 4'hF, 1);
  endtask

  // Hold the receiver off while the sender keeps offering, so the input stalls
  task automatic test_backpressure();
    gaps_on  = 1'b0;
    hold_len = 250;
    draw(100, 200, 160, 230, 16'h1234, 4'd3, 60);
    wait_drain();
    gaps_on = 1'b1;
  endtask

  // Random lines, mostly walked to the end, some dropped early, some noise words
  task automatic random_line();
    int xs, ys, xe, ye, span, n_adv, pick;
    xs = pick_coord();
    ys = pick_coord();
    pick = $urandom_range(0, 99);
    if (pick < 4) begin
      xe = pick_coord();
      ye = pick_coord();
    end else if (pick < 9) begin
      xe = xs;
      ye = ys;
    end else if (pick < 22) begin
      xe = xs;
      ye = ys;
      if ($urandom_range(0, 1) == 0) xe = clamp_coord(xs + $urandom_range(0, 48) - 24);
      else                           ye = clamp_coord(ys + $urandom_range(0, 48) - 24);
    end else begin
      xe = clamp_coord(xs + $urandom_range(0, 48) - 24);
      ye = clamp_coord(ys + $urandom_range(0, 48) - 24);
    end
    span = (xe > xs) ? xe - xs : xs - xe;
    if (((ye > ys) ? ye - ys : ys - ye) > span) span = (ye > ys) ? ye - ys : ys - ye;
    if (span > 48)                          n_adv = $urandom_range(0, 48);
    else if ($urandom_range(0, 9) == 0)     n_adv = $urandom_range(0, span);
    else if ($urandom_range(0, 3) == 0)     n_adv = span + $urandom_range(1, 2);
    else                                    n_adv = span;
    draw(coord_t'(xs), coord_t'(ys), coord_t'(xe), coord_t'(ye),
         16'($urandom()), 4'($urandom_range(0, 15)), n_adv);
  endtask

  task automatic test_random();
    int stop_at, pick;
    stop_at = words_sent + RandomWords;
    gaps_on = 1'b1;
    while (words_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 88) begin
        random_line();
      end else if (pick < 96) begin
        repeat ($urandom_range(1, 6)) send_word(noise_word(1'($urandom_range(0, 1))));
      end else if (pick < 98) begin
        gaps_on = !gaps_on;
      end else begin
        wait_drain();
      end
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_stall_i = 1'b0;
    mismatches  = 0;
    words_sent  = 0;
    cycles      = 0;
    burst_left  = 0;
    gaps_on     = 1'b1;
    hold_len    = 0;
    hold_left   = 0;
    phase_left  = 0;
    stall_mode  = StallNone;
    pen_color_q = '0;
    pen_size_q  = 4'd1;
    line_on     = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    test_directed();
    wait_drain();
    test_backpressure();
    test_random();
    wait_drain();
    repeat (20) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/lrast_pkg.sv
design/lrast_step.sv
design/line_rasterizer.sv
sim/tb_line_rasterizer.sv
